[design/hpq_pkg.sv]
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types, sizes and helpers of the level-cell heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int LEVELS   = $clog2(CAPACITY + 1);
  localparam int LVLW     = $clog2(LEVELS);
  localparam int ROWW     = (LEVELS > 2) ? LEVELS - 2 : 1;
  localparam int DW       = 32;
  localparam int OCCW     = 5;
  localparam int STW      = 2;

  typedef enum logic [STW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef enum logic {
    OP_INS,
    OP_SIFT
  } op_e;

  typedef struct packed {
    logic signed [DW-1:0] prio;
    logic signed [DW-1:0] data;
  } entry_t;

  // sibling pair, index 0 is the left child
  typedef entry_t [1:0] row_t;

  // INS: node is the target slot, lvl its level, swp set once the new entry
  // has taken an ancestor slot (every slot below on the path shifts down)
  // SIFT: node is the parent, prow the row that holds it
  typedef struct packed {
    logic            vld;
    op_e             op;
    logic            swp;
    logic [CW-1:0]   node;
    logic [LVLW-1:0] lvl;
    entry_t          carry;
    row_t            prow;
    logic [CW-1:0]   cnt;
  } tok_t;

  typedef struct packed {
    logic            vld;
    logic [ROWW-1:0] row;
    row_t            data;
  } wb_t;

  typedef struct packed {
    logic [CW-1:0]   node;
    logic [LVLW-1:0] lvl;
  } probe_t;

  typedef struct packed {
    logic signed [DW-1:0] data;
    logic signed [DW-1:0] prio;
    status_e              status;
    logic [OCCW-1:0]      occ;
  } res_t;

  function automatic logic prio_lt(entry_t a, entry_t b);
    return $signed(a.prio) < $signed(b.prio);
  endfunction

  // level of a 1-based heap index
  function automatic logic [LVLW-1:0] node_lvl(logic [CW-1:0] n);
    logic [LVLW-1:0] l;
    l = '0;
    for (int i = 0; i < CW; i++) begin
      if (n[i]) begin
        l = LVLW'(i);
      end
    end
    return l;
  endfunction

  function automatic logic [CW-1:0] node_off(logic [CW-1:0] n, logic [LVLW-1:0] lvl);
    logic [CW-1:0] mask;
    mask = (CW'(1) << lvl) - CW'(1);
    return n & mask;
  endfunction

  function automatic logic [ROWW-1:0] row_idx(logic [CW-1:0] n, logic [LVLW-1:0] lvl);
    logic [CW-1:0] o;
    o = node_off(n, lvl) >> 1;
    return o[ROWW-1:0];
  endfunction

  function automatic logic node_half(logic [CW-1:0] n, logic [LVLW-1:0] lvl);
    return (lvl == '0) ? 1'b0 : n[0];
  endfunction

  function automatic logic [OCCW-1:0] occ_of(logic [CW-1:0] cnt);
    logic [CW+OCCW-1:0] t;
    t = (CW + OCCW)'(cnt);
    return t[OCCW-1:0];
  endfunction

endpackage

`default_nettype wire

[design/hpq_ram.sv]
// ----------------------------------------------------------------------------
// hpq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/hpq_cell.sv]
// ----------------------------------------------------------------------------
// hpq_cell
// One heap level: reads its row, compares, writes back and hands the
// moving entry to the next level or a parent update to the level above.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [hpq_pkg::LVLW-1:0]    lvl_i,
  input  wire hpq_pkg::tok_t               tok_i,
  output hpq_pkg::tok_t                    tok_o,
  input  wire hpq_pkg::wb_t                wb_i,
  output hpq_pkg::wb_t                     wb_o,
  input  wire hpq_pkg::probe_t             probe_i,
  output logic                             fin_o,
  output logic                             ram_we_o,
  output logic [hpq_pkg::ROWW-1:0]         ram_waddr_o,
  output hpq_pkg::row_t                    ram_wdata_o,
  output logic [hpq_pkg::ROWW-1:0]         ram_raddr_o,
  input  wire hpq_pkg::row_t               ram_rdata_i
);

  typedef enum logic {
    C_IDLE,
    C_ACT
  } state_e;

  state_e                     state_q, state_d;
  hpq_pkg::tok_t              tk_q, tk_d;
  hpq_pkg::tok_t              tok_out_q, tok_out_d;
  hpq_pkg::wb_t               wb_q, wb_d;
  logic                       fin_q, fin_d;

  logic [hpq_pkg::CW-1:0]     anc_in, anc_act;
  logic [hpq_pkg::LVLW-1:0]   plvl;
  logic                       act_we;
  logic [hpq_pkg::ROWW-1:0]   act_waddr;
  hpq_pkg::row_t              act_wdata;
  logic                       h, ph, lv, rv, mv, bh;
  hpq_pkg::entry_t            bv;
  hpq_pkg::row_t              nr, pr;

  assign anc_in  = tok_i.node >> (tok_i.lvl - lvl_i);
  assign anc_act = tk_q.node >> (tk_q.lvl - lvl_i);
  assign plvl    = lvl_i - hpq_pkg::LVLW'(1);

  always_comb begin
    if (tok_i.vld) begin
      if (tok_i.op == hpq_pkg::OP_INS) begin
        ram_raddr_o = hpq_pkg::row_idx(anc_in, lvl_i);
      end else begin
        ram_raddr_o = hpq_pkg::ROWW'(hpq_pkg::node_off(tok_i.node, plvl));
      end
    end else begin
      ram_raddr_o = hpq_pkg::row_idx(probe_i.node, lvl_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    tk_d      = tk_q;
    tok_out_d = '0;
    wb_d      = '0;
    fin_d     = 1'b0;
    act_we    = 1'b0;
    act_waddr = '0;
    act_wdata = ram_rdata_i;
    h         = hpq_pkg::node_half(anc_act, lvl_i);
    ph        = hpq_pkg::node_half(tk_q.node, plvl);
    lv        = {tk_q.node, 1'b0} <= {1'b0, tk_q.cnt};
    rv        = {tk_q.node, 1'b1} <= {1'b0, tk_q.cnt};
    mv        = 1'b0;
    bh        = 1'b0;
    bv        = tk_q.carry;
    nr        = ram_rdata_i;
    pr        = tk_q.prow;

    case (state_q)
      C_IDLE: begin
        if (tok_i.vld) begin
          if (tok_i.op == hpq_pkg::OP_SIFT && lvl_i == '0) begin
            tok_out_d = tok_i;
          end else begin
            tk_d    = tok_i;
            state_d = C_ACT;
          end
        end
      end
      C_ACT: begin
        state_d = C_IDLE;
        if (tk_q.op == hpq_pkg::OP_INS) begin
          nr[h]     = tk_q.carry;
          act_waddr = hpq_pkg::row_idx(anc_act, lvl_i);
          act_wdata = nr;
          if (lvl_i == tk_q.lvl) begin
            act_we = 1'b1;
            fin_d  = 1'b1;
          end else begin
            tok_out_d     = tk_q;
            tok_out_d.vld = 1'b1;
            if (tk_q.swp || hpq_pkg::prio_lt(tk_q.carry, ram_rdata_i[h])) begin
              act_we          = 1'b1;
              tok_out_d.carry = ram_rdata_i[h];
              tok_out_d.swp   = 1'b1;
            end
          end
        end else begin
          if (lv && hpq_pkg::prio_lt(ram_rdata_i[0], bv)) begin
            mv = 1'b1;
            bh = 1'b0;
            bv = ram_rdata_i[0];
          end
          if (rv && hpq_pkg::prio_lt(ram_rdata_i[1], bv)) begin
            mv = 1'b1;
            bh = 1'b1;
            bv = ram_rdata_i[1];
          end
          pr[ph]    = bv;
          wb_d.vld  = 1'b1;
          wb_d.row  = hpq_pkg::row_idx(tk_q.node, plvl);
          wb_d.data = pr;
          if (!mv) begin
            fin_d = 1'b1;
          end else if ({tk_q.node, bh, 1'b0} <= {2'b00, tk_q.cnt}) begin
            tok_out_d      = tk_q;
            tok_out_d.node = {tk_q.node[hpq_pkg::CW-2:0], bh};
            tok_out_d.prow = ram_rdata_i;
          end else begin
            nr[bh]    = tk_q.carry;
            act_we    = 1'b1;
            act_waddr = hpq_pkg::ROWW'(hpq_pkg::node_off(tk_q.node, plvl));
            act_wdata = nr;
            fin_d     = 1'b1;
          end
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_IDLE;
      tk_q      <= '0;
      tok_out_q <= '0;
      wb_q      <= '0;
      fin_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      tk_q      <= tk_d;
      tok_out_q <= tok_out_d;
      wb_q      <= wb_d;
      fin_q     <= fin_d;
    end
  end

  assign ram_we_o    = act_we | wb_i.vld;
  assign ram_waddr_o = wb_i.vld ? wb_i.row : act_waddr;
  assign ram_wdata_o = wb_i.vld ? wb_i.data : act_wdata;
  assign tok_o       = tok_out_q;
  assign wb_o        = wb_q;
  assign fin_o       = fin_q;

endmodule

`default_nettype wire

[design/hpq_ctrl.sv]
// ----------------------------------------------------------------------------
// hpq_ctrl
// Request sequencer: entry count, root and last-entry fetch, token launch
// into the level chain and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_ctrl (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_tvalid_i,
  output logic                                       s_tready_o,
  input  wire logic                                  req_type_i,
  input  wire logic signed [hpq_pkg::DW-1:0]         item_data_i,
  input  wire logic signed [hpq_pkg::DW-1:0]         item_priority_i,
  output hpq_pkg::tok_t                              tok_o,
  output hpq_pkg::probe_t                            probe_o,
  input  wire hpq_pkg::row_t [hpq_pkg::LEVELS-1:0]   rows_i,
  input  wire logic                                  done_i,
  output logic                                       m_tvalid_o,
  input  wire logic                                  m_tready_i,
  output hpq_pkg::res_t                              res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_FETCH,
    S_RUN,
    S_RESP
  } state_e;

  state_e                  state_q, state_d;
  logic [hpq_pkg::CW-1:0]  cnt_q, cnt_d;
  hpq_pkg::tok_t           tok_q, tok_d;
  hpq_pkg::probe_t         probe_q, probe_d;
  hpq_pkg::res_t           res_q, res_d;
  hpq_pkg::res_t           out_q, out_d;
  logic                    out_vld_q, out_vld_d;
  logic [hpq_pkg::CW-1:0]  n_ins;
  hpq_pkg::entry_t         last;

  assign n_ins = cnt_q + hpq_pkg::CW'(1);
  assign last  = rows_i[probe_q.lvl][hpq_pkg::node_half(probe_q.node, probe_q.lvl)];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    tok_d     = '0;
    probe_d   = probe_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && m_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          res_d.data = '0;
          res_d.prio = '0;
          if (req_type_i == hpq_pkg::REQ_ENQ) begin
            if (cnt_q == hpq_pkg::CW'(hpq_pkg::CAPACITY)) begin
              res_d.status = hpq_pkg::ST_FULL;
              res_d.occ    = hpq_pkg::occ_of(cnt_q);
              state_d      = S_RESP;
            end else begin
              tok_d.vld        = 1'b1;
              tok_d.op         = hpq_pkg::OP_INS;
              tok_d.node       = n_ins;
              tok_d.lvl        = hpq_pkg::node_lvl(n_ins);
              tok_d.carry.data = item_data_i;
              tok_d.carry.prio = item_priority_i;
              tok_d.cnt        = n_ins;
              cnt_d            = n_ins;
              res_d.status     = hpq_pkg::ST_DONE;
              res_d.occ        = hpq_pkg::occ_of(n_ins);
              state_d          = S_RUN;
            end
          end else begin
            if (cnt_q == '0) begin
              res_d.status = hpq_pkg::ST_EMPTY;
              res_d.occ    = hpq_pkg::occ_of(cnt_q);
              state_d      = S_RESP;
            end else begin
              probe_d.node = cnt_q;
              probe_d.lvl  = hpq_pkg::node_lvl(cnt_q);
              cnt_d        = cnt_q - hpq_pkg::CW'(1);
              state_d      = S_PROBE;
            end
          end
        end
      end
      S_PROBE: begin
        state_d = S_FETCH;
      end
      S_FETCH: begin
        res_d.data   = rows_i[0][0].data;
        res_d.prio   = rows_i[0][0].prio;
        res_d.status = hpq_pkg::ST_DONE;
        res_d.occ    = hpq_pkg::occ_of(cnt_q);
        if (cnt_q == '0) begin
          state_d = S_RESP;
        end else begin
          tok_d.vld   = 1'b1;
          tok_d.op    = hpq_pkg::OP_SIFT;
          tok_d.node  = hpq_pkg::CW'(1);
          tok_d.lvl   = '0;
          tok_d.carry = last;
          tok_d.prow  = rows_i[0];
          tok_d.cnt   = cnt_q;
          state_d     = S_RUN;
        end
      end
      S_RUN: begin
        if (done_i) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_vld_q || m_tready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      tok_q     <= '0;
      probe_q   <= '0;
      res_q     <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      tok_q     <= tok_d;
      probe_q   <= probe_d;
      res_q     <= res_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign tok_o      = tok_q;
  assign probe_o    = probe_q;
  assign m_tvalid_o = out_vld_q;
  assign res_o      = out_q;

endmodule

`default_nettype wire

[design/binary_min_heap_priority_queue.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue
// Fixed-capacity min-heap priority queue built as a chain of level cells.
//
//   port group  dir  tdata (low bit up)                     tuser
//   s_axis      in   item_data[31:0] item_priority[63:32]   req_type
//   m_axis      out  out_data[31:0] out_priority[63:32]     status[1:0]
//                    occupancy[68:64], zero pad [71:69]
//
// One request in flight. Each heap level is a cell with its own row RAM that
// does a registered read, then a compare and write. Full and empty requests
// answer without entering the level chain. s_axis is ready again in the same
// cycle that the result goes valid. Reset clears the count and control only.
// A result waiting on m_axis does not block the next s_axis transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_priority_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // item_data, item_priority
  input  wire logic [0:0]  s_axis_tuser_i,   // req_type
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,   // out_data, out_priority, occupancy
  output logic [1:0]       m_axis_tuser_o    // status
);

  hpq_pkg::tok_t                       tok   [hpq_pkg::LEVELS+1];
  hpq_pkg::wb_t                        wb    [hpq_pkg::LEVELS+1];
  logic [hpq_pkg::LEVELS-1:0]          fin;
  hpq_pkg::probe_t                     probe;
  hpq_pkg::row_t [hpq_pkg::LEVELS-1:0] rows;
  hpq_pkg::res_t                       res;
  logic                                done;

  logic [hpq_pkg::LEVELS-1:0]          ram_we;
  logic [hpq_pkg::ROWW-1:0]            ram_waddr [hpq_pkg::LEVELS];
  hpq_pkg::row_t                       ram_wdata [hpq_pkg::LEVELS];
  logic [hpq_pkg::ROWW-1:0]            ram_raddr [hpq_pkg::LEVELS];

  assign wb[hpq_pkg::LEVELS] = '0;
  assign done = (|fin) | tok[hpq_pkg::LEVELS].vld | wb[0].vld;

  hpq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid_i),
    .s_tready_o      (s_axis_tready_o),
    .req_type_i      (s_axis_tuser_i[0]),
    .item_data_i     (s_axis_tdata_i[31:0]),
    .item_priority_i (s_axis_tdata_i[63:32]),
    .tok_o           (tok[0]),
    .probe_o         (probe),
    .rows_i          (rows),
    .done_i          (done),
    .m_tvalid_o      (m_axis_tvalid_o),
    .m_tready_i      (m_axis_tready_i),
    .res_o           (res)
  );

  for (genvar k = 0; k < hpq_pkg::LEVELS; k++) begin : g_lvl
    localparam int DEPTH = (k < 2) ? 1 : (1 << (k - 1));
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    hpq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .lvl_i       (hpq_pkg::LVLW'(k)),
      .tok_i       (tok[k]),
      .tok_o       (tok[k+1]),
      .wb_i        (wb[k+1]),
      .wb_o        (wb[k]),
      .probe_i     (probe),
      .fin_o       (fin[k]),
      .ram_we_o    (ram_we[k]),
      .ram_waddr_o (ram_waddr[k]),
      .ram_wdata_o (ram_wdata[k]),
      .ram_raddr_o (ram_raddr[k]),
      .ram_rdata_i (rows[k])
    );

    hpq_ram #(
      .WIDTH ($bits(hpq_pkg::row_t)),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[k]),
      .waddr_i (ram_waddr[k][AW-1:0]),
      .wdata_i (ram_wdata[k]),
      .raddr_i (ram_raddr[k][AW-1:0]),
      .rdata_o (rows[k])
    );
  end

  assign m_axis_tdata_o = {3'b000, res.occ, res.prio, res.data};
  assign m_axis_tuser_o = res.status;

endmodule

`default_nettype wire
